/* hdl/rde_pkg.sv */
// Shared types and constants for the radix digit emitter.
package rde_pkg;

	// Fixed field widths of the channels
	localparam int VAL_W     = 64;
	localparam int RADIX_W   = 5;
	localparam int PREC_W    = 8;
	localparam int CHAR_W    = 8;
	localparam int CNT_W     = 7;
	localparam int DIGIT_W   = 4;
	localparam int TBL_W     = 64;
	localparam int CFG_IDX_W = 2;

	// Quotient bits retired per divider step
	localparam int STEP_BITS = 4;

	// Padding character
	localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;

	// Radix limits
	localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TABLE_A_LOW  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TABLE_A_HIGH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TABLE_B_LOW  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TABLE_B_HIGH = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_EMIT
	} rde_state_t;

endpackage

/* hdl/rde_if.sv */
// Channel interfaces: conversion requests, characters out, table writes.
interface rde_conv_if;
	logic                                valid;
	logic                                ready;
	logic [rde_pkg::VAL_W-1:0]           value;
	logic [rde_pkg::RADIX_W-1:0]         radix;
	logic                                table_select;
	logic signed [rde_pkg::PREC_W-1:0]   min_digits;

	modport source(output valid, value, radix, table_select, min_digits, input ready);
	modport sink(input valid, value, radix, table_select, min_digits, output ready);
endinterface

interface rde_chars_if;
	logic                         valid;
	logic                         ready;
	logic [rde_pkg::CHAR_W-1:0]   character;
	logic                         last_char;
	logic [rde_pkg::CNT_W-1:0]    total_chars;

	modport source(output valid, character, last_char, total_chars, input ready);
	modport sink(input valid, character, last_char, total_chars, output ready);
endinterface

interface rde_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [rde_pkg::CFG_IDX_W-1:0]   index;
	logic [rde_pkg::TBL_W-1:0]       data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

/* hdl/radix_digit_emitter_top.sv */
// Unsigned integer to text in radix 2..16 with printf precision.
//
//  channel | dir | transaction
//  --------+-----+-------------------------------------------------
//  conv    | in  | one conversion: value, radix, table_select, min_digits
//  chars   | out | one character with last_char and total_chars
//  cfg     | in  | one digit table word write, always ready
//
// Flow: accept, then one division per digit (one shared divider retiring
// 4 quotient bits a cycle), then one character emitted per cycle when the
// sink takes each at once.
// conv is ready only when idle; a zero value with precision 0 returns to
// idle with no character. chars is held in an output register, so a stall
// only freezes emission. arst_n clears the controller and digit tables.
module radix_digit_emitter_top #(
	parameter int VALUE_WIDTH = 64,
	parameter int MAX_CHARS   = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	rde_conv_if.sink          conv,
	rde_chars_if.source       chars,
	rde_cfg_if.sink           cfg
);
	import rde_pkg::*;

	localparam int PW      = ((VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS) * STEP_BITS;
	localparam int NSTEP   = PW / STEP_BITS;
	localparam int STEP_CW = $clog2(NSTEP);
	localparam int CW      = $clog2(MAX_CHARS + 1);

	rde_state_t state_q, state_d;

	logic [PW-1:0]          dvd_q;
	logic [DIGIT_W-1:0]     rem_q;
	logic [RADIX_W-1:0]     rad_q;
	logic                   sel_q;
	logic [CW-1:0]          prec_q;
	logic [STEP_CW-1:0]     step_q;
	logic [CW-1:0]          nd_q;
	logic [CW-1:0]          total_q;
	logic [CW-1:0]          emit_q;
	logic [DIGIT_W-1:0]     dig_q [MAX_CHARS];
	logic [TBL_W-1:0]       tbl_q [4];

	logic                   ovalid_q;
	logic [CHAR_W-1:0]      ochar_q;
	logic                   olast_q;
	logic [CNT_W-1:0]       ototal_q;

	logic                   accept;
	logic                   skip;
	logic                   load;
	logic                   last_step;
	logic                   div_done;
	logic                   push;
	logic [STEP_BITS-1:0]   qbits;
	logic [DIGIT_W-1:0]     rem_d;
	logic [PW-1:0]          dvd_d;
	logic [CW-1:0]          nd_d;
	logic [CW-1:0]          total_d;
	logic                   is_pad;
	logic                   is_last;
	logic [TBL_W-1:0]       tbl_word;
	logic [CHAR_W-1:0]      dig_char;
	logic [RADIX_W-1:0]     rad_in;
	logic [CW-1:0]          prec_in;

	// Input decode: clamp radix and precision
	always_comb begin
		if (conv.radix < RADIX_MIN) begin
			rad_in = RADIX_MIN;
		end else if (conv.radix > RADIX_MAX) begin
			rad_in = RADIX_MAX;
		end else begin
			rad_in = conv.radix;
		end
		if (conv.min_digits[PREC_W-1]) begin
			prec_in = '0;
		end else if (conv.min_digits[PREC_W-2:0] > (PREC_W-1)'(MAX_CHARS)) begin
			prec_in = CW'(MAX_CHARS);
		end else begin
			prec_in = CW'(conv.min_digits[PREC_W-2:0]);
		end
	end

	assign skip = (conv.min_digits == '0) && (conv.value[VALUE_WIDTH-1:0] == '0);

	// Shared divider: four restoring steps of the running remainder
	always_comb begin
		logic [DIGIT_W:0]   t;
		logic [DIGIT_W-1:0] r;
		r = rem_q;
		qbits = '0;
		for (int b = 0; b < STEP_BITS; b++) begin
			t = {r, dvd_q[PW-1-b]};
			if (t >= rad_q) begin
				qbits[STEP_BITS-1-b] = 1'b1;
				r = DIGIT_W'(t - rad_q);
			end else begin
				r = t[DIGIT_W-1:0];
			end
		end
		rem_d = r;
		dvd_d = {dvd_q[PW-STEP_BITS-1:0], qbits};
	end

	assign last_step = (step_q == STEP_CW'(NSTEP - 1));
	assign push      = (nd_q < CW'(MAX_CHARS));
	assign nd_d      = nd_q + CW'(push);
	assign total_d   = (prec_q > nd_d) ? prec_q : nd_d;

	// Character selection for emission
	assign is_pad   = (emit_q < (total_q - nd_q));
	assign is_last  = (emit_q == (total_q - CW'(1)));
	assign tbl_word = tbl_q[{sel_q, dig_q[MAX_CHARS-1][DIGIT_W-1]}];
	assign dig_char = tbl_word[dig_q[MAX_CHARS-1][DIGIT_W-2:0] * CHAR_W +: CHAR_W];

	// Sequencer: next state and handshakes
	always_comb begin
		state_d  = state_q;
		accept   = 1'b0;
		load     = 1'b0;
		div_done = 1'b0;
		conv.ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				conv.ready = 1'b1;
				if (conv.valid) begin
					accept = 1'b1;
					if (!skip) begin
						state_d = ST_DIV;
					end
				end
			end
			ST_DIV: begin
				if (last_step && (dvd_d == '0)) begin
					div_done = 1'b1;
					state_d  = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (!ovalid_q || chars.ready) begin
					load = 1'b1;
					if (is_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Conversion datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			dvd_q  <= PW'(conv.value[VALUE_WIDTH-1:0]);
			rad_q  <= rad_in;
			sel_q  <= conv.table_select;
			prec_q <= prec_in;
			rem_q  <= '0;
			step_q <= '0;
			nd_q   <= '0;
			emit_q <= '0;
		end else if (state_q == ST_DIV) begin
			dvd_q <= dvd_d;
			if (last_step) begin
				rem_q  <= '0;
				step_q <= '0;
				nd_q   <= nd_d;
				if (div_done) begin
					total_q <= total_d;
				end
			end else begin
				rem_q  <= rem_d;
				step_q <= step_q + STEP_CW'(1);
			end
		end else if (load) begin
			emit_q <= emit_q + CW'(1);
		end
	end

	// Digit stack: pushed in at the top, popped from the top
	always_ff @(posedge clk) begin
		if ((state_q == ST_DIV) && last_step && push) begin
			for (int i = 0; i < MAX_CHARS - 1; i++) begin
				dig_q[i] <= dig_q[i+1];
			end
			dig_q[MAX_CHARS-1] <= rem_d;
		end else if (load && !is_pad) begin
			for (int i = MAX_CHARS - 1; i > 0; i--) begin
				dig_q[i] <= dig_q[i-1];
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (load) begin
			ovalid_q <= 1'b1;
		end else if (chars.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ochar_q  <= is_pad ? CHAR_ZERO : dig_char;
			olast_q  <= is_last;
			ototal_q <= CNT_W'(total_q);
		end
	end

	assign chars.valid       = ovalid_q;
	assign chars.character   = ochar_q;
	assign chars.last_char   = olast_q;
	assign chars.total_chars = ototal_q;

	// Digit table registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				tbl_q[i] <= '0;
			end
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_TABLE_A_LOW:  tbl_q[0] <= cfg.data;
				REG_TABLE_A_HIGH: tbl_q[1] <= cfg.data;
				REG_TABLE_B_LOW:  tbl_q[2] <= cfg.data;
				REG_TABLE_B_HIGH: tbl_q[3] <= cfg.data;
				default: ;
			endcase
		end
	end

	assign cfg.ready = 1'b1;

endmodule

/* hdl/rde_checker.sv */
// Port-level checks for the radix digit emitter, bound to the top level.
module rde_checker #(
	parameter int MAX_CHARS = 64
) (
	input logic       clk,
	input logic       arst_n,
	input logic       conv_valid,
	input logic       conv_ready,
	input logic       chars_valid,
	input logic       chars_ready,
	input logic [7:0] chars_character,
	input logic       chars_last_char,
	input logic [6:0] chars_total_chars
);

	// A stalled character holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		chars_valid && !chars_ready |=> chars_valid && $stable(chars_character)
			&& $stable(chars_last_char) && $stable(chars_total_chars))
		else $error("character changed while stalled");

	// Input stays closed while a conversion still has characters to emit
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		chars_valid && !chars_last_char |-> !conv_ready)
		else $error("ready while a conversion is still emitting");

	// Total count is constant within a conversion
	a_total_steady: assert property (@(posedge clk) disable iff (!arst_n)
		chars_valid && chars_ready && !chars_last_char
			|=> chars_total_chars == $past(chars_total_chars))
		else $error("total count changed inside a conversion");

	// When idle, any pending character is the final one, within range
	a_idle_last: assert property (@(posedge clk) disable iff (!arst_n)
		conv_ready && chars_valid |-> chars_last_char && chars_total_chars != 7'd0
			&& chars_total_chars <= 7'(MAX_CHARS))
		else $error("idle with a conversion still in flight");

endmodule

bind radix_digit_emitter_top rde_checker #(.MAX_CHARS(MAX_CHARS)) u_rde_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.conv_valid       (conv.valid),
	.conv_ready       (conv.ready),
	.chars_valid      (chars.valid),
	.chars_ready      (chars.ready),
	.chars_character  (chars.character),
	.chars_last_char  (chars.last_char),
	.chars_total_chars(chars.total_chars)
);

/* tb/rde_char_checker.sv */
// Checker for the radix digit emitter: predicts the character stream and compares it.
`timescale 1ns / 100ps

module rde_char_checker (
	input  logic clk,
	input  logic arst_n,
	rde_conv_if  conv,
	rde_chars_if chars,
	rde_cfg_if   cfg,
	output int   mismatches,
	output int   outstanding
);
	import rde_pkg::*;

	localparam int MAX_CHARS = 64;

	typedef struct packed {
		logic [CHAR_W-1:0] character;
		logic              last_char;
		logic [CNT_W-1:0]  total_chars;
	} char_rec_t;

	// Mirror of the digit tables, indexed {table_select, digit[3]}
	logic [TBL_W-1:0] digit_tables [4];
	char_rec_t        char_q [$];
	int               err_cnt;

	// Queue the characters one conversion should produce
	function automatic void spell_number(logic [VAL_W-1:0] value, logic [RADIX_W-1:0] radix,
			logic sel, logic [PREC_W-1:0] prec_bits);
		logic [VAL_W-1:0]   rest;
		logic [VAL_W-1:0]   base;
		logic [DIGIT_W-1:0] digs [64];
		logic [DIGIT_W-1:0] d;
		logic [TBL_W-1:0]   word;
		int                 prec;
		int                 nd;
		int                 total;
		int                 zeros;
		char_rec_t          rec;

		rest = value;
		base = VAL_W'(radix);
		if (base < VAL_W'(RADIX_MIN)) begin
			base = VAL_W'(RADIX_MIN);
		end
		if (base > VAL_W'(RADIX_MAX)) begin
			base = VAL_W'(RADIX_MAX);
		end
		// any negative precision means none
		prec = prec_bits[PREC_W-1] ? -1 : int'(prec_bits);
		if (prec > MAX_CHARS) begin
			prec = MAX_CHARS;
		end
		// zero with precision 0 prints nothing
		if (prec == 0 && rest == '0) begin
			return;
		end

		// least significant digit first
		nd = 0;
		do begin
			if (nd < 64) begin
				digs[nd] = DIGIT_W'(rest % base);
			end
			nd++;
			rest = rest / base;
		end while (rest != '0);
		if (nd > MAX_CHARS) begin
			nd = MAX_CHARS;
		end

		total = (prec > nd) ? prec : nd;
		zeros = total - nd;
		for (int k = 0; k < total; k++) begin
			if (k < zeros) begin
				rec.character = CHAR_ZERO;
			end else begin
				d = digs[nd - 1 - (k - zeros)];
				word = digit_tables[{sel, d[3]}];
				rec.character = word[d[2:0]*8 +: 8];
			end
			rec.last_char   = (k == total - 1);
			rec.total_chars = CNT_W'(total);
			char_q.push_back(rec);
		end
	endfunction

	// Watch all three channels on the rising edge
	always @(posedge clk or negedge arst_n) begin
		char_rec_t want;

		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				digit_tables[i] = '0;
			end
			char_q.delete();
			err_cnt = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				digit_tables[cfg.index] = cfg.data;
			end
			if (conv.valid && conv.ready) begin
				spell_number(conv.value, conv.radix, conv.table_select, conv.min_digits);
			end
			if (chars.valid && chars.ready) begin
				if (char_q.size() == 0) begin
					$error("unexpected character transaction: character %h", chars.character);
					err_cnt++;
				end else begin
					want = char_q.pop_front();
					if (chars.character !== want.character) begin
						$error("character: expected %h, got %h", want.character, chars.character);
						err_cnt++;
					end
					if (chars.last_char !== want.last_char) begin
						$error("last_char: expected %b, got %b", want.last_char, chars.last_char);
						err_cnt++;
					end
					if (chars.total_chars !== want.total_chars) begin
						$error("total_chars: expected %0d, got %0d",
							want.total_chars, chars.total_chars);
						err_cnt++;
					end
				end
			end
		end
		mismatches  <= err_cnt;
		outstanding <= char_q.size();
	end

endmodule

/* tb/radix_digit_emitter_top_tb.sv */
// Testbench top for the radix digit emitter: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module radix_digit_emitter_top_tb;
	import rde_pkg::*;

	localparam int SETTLE_CYCLES   = 1200;  // radix 2, 64 digits, plus emission
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int WATCHDOG_LIMIT  = 6000;

	// digit tables, digit k in byte k
	localparam logic [TBL_W-1:0] LOWER_LO = 64'h3736353433323130;
	localparam logic [TBL_W-1:0] LOWER_HI = 64'h6665646362613938;
	localparam logic [TBL_W-1:0] UPPER_HI = 64'h4645444342413938;

	logic clk = 1'b0;
	logic arst_n;
	bit   calm = 1'b0;
	bit   hold_off = 1'b0;
	int   mismatches;
	int   outstanding;
	int   quiet_cycles;

	rde_conv_if  conv_bus ();
	rde_chars_if chars_bus ();
	rde_cfg_if   cfg_bus ();

	radix_digit_emitter_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.conv   (conv_bus),
		.chars  (chars_bus),
		.cfg    (cfg_bus)
	);

	rde_char_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.conv        (conv_bus),
		.chars       (chars_bus),
		.cfg         (cfg_bus),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always #6 clk = ~clk;

	// Watchdog: too long with no transaction on any channel
	always @(posedge clk) begin
		if (!arst_n || (conv_bus.valid && conv_bus.ready) || (chars_bus.valid && chars_bus.ready)
				|| (cfg_bus.valid && cfg_bus.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("radix_digit_emitter_top_tb: done, errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Character sink: random stall bursts, one long hold-off on request
	initial begin
		int stall;

		chars_bus.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off) begin
				chars_bus.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES - 1) @(posedge clk);
				hold_off = 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				stall = $urandom_range(1, 16);
				chars_bus.ready <= 1'b0;
				repeat (stall - 1) @(posedge clk);
			end else begin
				chars_bus.ready <= 1'b1;
			end
		end
	end

	// One conversion transaction, with an optional idle burst ahead of it
	task automatic send_conv(input logic [VAL_W-1:0] value, input logic [RADIX_W-1:0] radix,
			input logic sel, input logic [PREC_W-1:0] prec);
		int gap;

		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 16);
			conv_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		conv_bus.valid        <= 1'b1;
		conv_bus.value        <= value;
		conv_bus.radix        <= radix;
		conv_bus.table_select <= sel;
		conv_bus.min_digits   <= prec;
		@(posedge clk);
		while (!conv_bus.ready) @(posedge clk);
	endtask

	task automatic send_random(input int count);
		int                 len;
		logic [VAL_W-1:0]   value;
		logic [RADIX_W-1:0] radix;
		logic [PREC_W-1:0]  prec;

		for (int i = 0; i < count; i++) begin
			// spread value magnitudes over all bit lengths
			len = $urandom_range(1, VAL_W);
			value = {$urandom, $urandom} >> (VAL_W - len);
			if ($urandom_range(0, 9) == 0) begin
				value = '0;
			end
			if ($urandom_range(0, 9) == 0) begin
				radix = RADIX_W'($urandom_range(0, 31));
			end else begin
				radix = RADIX_W'($urandom_range(2, 16));
			end
			case ($urandom_range(0, 5))
				0, 1: prec = 8'hFF;
				2, 3: prec = PREC_W'($urandom_range(0, 20));
				4: prec = PREC_W'($urandom_range(0, 70));
				default: prec = PREC_W'($urandom_range(0, 255));
			endcase
			send_conv(value, radix, 1'($urandom_range(0, 1)), prec);
		end
	endtask

	task automatic put_table_word(input logic [CFG_IDX_W-1:0] index, input logic [TBL_W-1:0] data);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= index;
		cfg_bus.data  <= data;
		@(posedge clk);
		while (!cfg_bus.ready) @(posedge clk);
	endtask

	// Reload both tables once the block has gone quiet
	task automatic load_tables(input logic [TBL_W-1:0] a_lo, input logic [TBL_W-1:0] a_hi,
			input logic [TBL_W-1:0] b_lo, input logic [TBL_W-1:0] b_hi);
		conv_bus.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		put_table_word(REG_TABLE_A_LOW, a_lo);
		put_table_word(REG_TABLE_A_HIGH, a_hi);
		put_table_word(REG_TABLE_B_LOW, b_lo);
		put_table_word(REG_TABLE_B_HIGH, b_hi);
		cfg_bus.valid <= 1'b0;
	endtask

	// Stimulus and verdict
	initial begin
		arst_n                <= 1'b0;
		conv_bus.valid        <= 1'b0;
		conv_bus.value        <= '0;
		conv_bus.radix        <= '0;
		conv_bus.table_select <= 1'b0;
		conv_bus.min_digits   <= '0;
		cfg_bus.valid         <= 1'b0;
		cfg_bus.index         <= REG_TABLE_A_LOW;
		cfg_bus.data          <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// lowercase in A, uppercase in B
		load_tables(LOWER_LO, LOWER_HI, LOWER_LO, UPPER_HI);

		// directed: zero cases, widest values, clamped radix and precision
		send_conv('0, 5'd10, 1'b0, 8'd0);
		send_conv('0, 5'd10, 1'b0, 8'hFF);
		send_conv('0, 5'd16, 1'b1, 8'd5);
		send_conv('0, 5'd2, 1'b1, 8'd64);
		send_conv('1, 5'd2, 1'b0, 8'hFF);
		send_conv('1, 5'd16, 1'b1, 8'hFF);
		send_conv('1, 5'd10, 1'b0, 8'd0);
		send_conv('1, 5'd3, 1'b1, 8'd10);
		send_conv(64'hFEDCBA9876543210, 5'd16, 1'b0, 8'hFF);
		send_conv(64'hFEDCBA9876543210, 5'd16, 1'b1, 8'hFF);
		send_conv(64'd1, 5'd0, 1'b0, 8'd3);
		send_conv(64'd5, 5'd1, 1'b1, 8'hFF);
		send_conv('1, 5'd31, 1'b0, 8'hFF);
		send_conv(64'd255, 5'd17, 1'b1, 8'd2);
		send_conv(64'd7, 5'd2, 1'b0, 8'd64);
		send_conv(64'd7, 5'd3, 1'b1, 8'd127);
		send_conv(64'h8000000000000000, 5'd8, 1'b0, 8'd65);
		send_conv(64'd123, 5'd10, 1'b0, 8'h80);
		send_conv(64'd123, 5'd10, 1'b1, 8'hFE);
		send_conv(64'd1, 5'd16, 1'b0, 8'd0);
		send_conv(64'd15, 5'd15, 1'b0, 8'd1);
		send_conv(64'd100, 5'd7, 1'b1, 8'd3);
		send_random(20);

		// table extremes: all ones and all zeros
		load_tables('1, '1, '0, '0);
		send_random(15);

		// random tables; the sink holds off while conversions keep coming
		load_tables({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
			{$urandom, $urandom});
		send_random(8);
		hold_off = 1'b1;
		send_random(17);

		// swapped extremes, no idling on either side
		load_tables('0, '0, '1, '1);
		calm = 1'b1;
		send_random(20);

		conv_bus.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("radix_digit_emitter_top_tb: done, clean");
		end else begin
			$display("radix_digit_emitter_top_tb: done, errors");
		end
		$finish;
	end

endmodule

/* radix_digit_emitter_top.f */
hdl/rde_pkg.sv
hdl/rde_if.sv
hdl/radix_digit_emitter_top.sv
hdl/rde_checker.sv
tb/rde_char_checker.sv
tb/radix_digit_emitter_top_tb.sv
